### rtl/kcs_pkg.sv
package kcs_pkg;

   localparam int MaxKeysDefault = 256;
   localparam int TimeW = 32;
   localparam int ValW = 32;
   localparam int FracW = 17;
   localparam int CountW = 9;

   localparam logic CmdWrite = 1'b0;
   localparam logic CmdSample = 1'b1;

   typedef struct packed {
      logic command;
      logic [7:0] key_slot;
      logic [31:0] key_time;
      logic signed [31:0] key_x;
      logic signed [31:0] key_y;
      logic signed [31:0] key_z;
      logic signed [31:0] key_w;
      logic [31:0] sample_time;
   } req_type;

   typedef struct packed {
      logic signed [31:0] value_x;
      logic signed [31:0] value_y;
      logic signed [31:0] value_z;
      logic signed [31:0] value_w;
      logic held;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_RD0,
      ST_CHK0,
      ST_SRCH,
      ST_SCMP,
      ST_DIV,
      ST_RDB,
      ST_MUL,
      ST_LERP,
      ST_OUT
   } state_type;

endpackage

### rtl/kcs_divider.sv
// Restoring divider: quotient = (num << 16) / den, 17-bit result, one bit per cycle.
module kcs_divider (
   input  logic clock,
   input  logic reset,
   input  logic start,
   input  logic [31:0] num,
   input  logic [31:0] den,
   output logic done,
   output logic [kcs_pkg::FracW-1:0] quot
);
   import kcs_pkg::*;

   logic [32:0] rem_ff, rem_in;
   logic [47:0] shf_ff, shf_in;
   logic [31:0] den_ff, den_in;
   logic [FracW-1:0] q_ff, q_in;
   logic [5:0] cnt_ff, cnt_in;
   logic busy_ff, busy_in;
   logic [33:0] trial;
   logic [32:0] rsh;

   always_comb begin
      rem_in = rem_ff;
      shf_in = shf_ff;
      den_in = den_ff;
      q_in = q_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      rsh = '0;
      trial = '0;
      if (start) begin
         rem_in = '0;
         shf_in = {num, 16'd0};
         den_in = den;
         q_in = '0;
         cnt_in = 6'd48;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rsh = {rem_ff[31:0], shf_ff[47]};
         trial = {1'b0, rsh} - {2'b00, den_ff};
         shf_in = {shf_ff[46:0], 1'b0};
         if (!trial[33]) begin
            rem_in = trial[32:0];
            q_in = {q_ff[FracW-2:0], 1'b1};
         end else begin
            rem_in = rsh;
            q_in = {q_ff[FracW-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 6'd1;
         if (cnt_ff == 6'd1) busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff <= cnt_in;
      end
      rem_ff <= rem_in;
      shf_ff <= shf_in;
      den_ff <= den_in;
      q_ff <= q_in;
   end

   assign done = busy_ff && (cnt_ff == 6'd1) && !start;
   assign quot = q_in;
endmodule

### rtl/kcs_key_store.sv
// Key table: time and value memories, one write and one registered read per cycle.
module kcs_key_store #(
   parameter int MaxKeys = kcs_pkg::MaxKeysDefault,
   parameter int AddrW = $clog2(MaxKeys)
) (
   input  logic clock,
   input  logic wr_en,
   input  logic [AddrW-1:0] wr_addr,
   input  logic [31:0] wr_time,
   input  logic [127:0] wr_val,
   input  logic [AddrW-1:0] rd_addr,
   output logic [31:0] rd_time,
   output logic [127:0] rd_val
);
   import kcs_pkg::*;

   logic [31:0] time_mem [MaxKeys];
   logic [127:0] val_mem [MaxKeys];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         time_mem[wr_addr] <= wr_time;
         val_mem[wr_addr] <= wr_val;
      end
      rd_time <= time_mem[rd_addr];
      rd_val <= val_mem[rd_addr];
   end
endmodule

### rtl/keyframe_curve_sampler.sv
// Write beat: no response; writes can follow back to back while no rsp is pending.
// Sample beat: key 0 is read and answers directly; otherwise the segments are scanned,
// ending held past the last key or going on to the fraction divide, multiply and lerp.
// The scan reads then compares one key memory entry at a time; the divider retires one
// quotient bit a cycle. One item in flight; next beat taken after the rsp beat.
// Synchronous active-high reset: key count = 1, last result = 0, no rsp; keys not reset.
module keyframe_curve_sampler #(
   parameter int MaxKeys = kcs_pkg::MaxKeysDefault
) (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_ready,
   input  kcs_pkg::req_type req_data,
   output logic rsp_valid,
   input  logic rsp_ready,
   output kcs_pkg::rsp_type rsp_data,
   input  logic csr_we,
   input  logic [kcs_pkg::CountW-1:0] csr_wdata
);
   import kcs_pkg::*;

   localparam int AddrW = $clog2(MaxKeys);
   localparam int IdxW = AddrW + 1;

   state_type state_ff, state_in;
   logic [CountW-1:0] nkeys_ff;
   logic [IdxW-1:0] nsat;
   logic [IdxW-1:0] idx_ff, idx_in;
   logic [31:0] t_ff, t_in;
   logic [31:0] t0_ff, t0_in;
   logic [127:0] va_ff, va_in;
   logic [127:0] vb_ff, vb_in;
   logic [FracW-1:0] f_ff, f_in;
   logic signed [49:0] prod_ff [4];
   logic signed [49:0] prod_in [4];
   logic [127:0] last_ff, last_in;
   logic held_ff, held_in;
   logic rspv_ff, rspv_in;
   logic [AddrW-1:0] rd_addr;
   logic [31:0] rd_time;
   logic [127:0] rd_val;
   logic div_start, div_done;
   logic [FracW-1:0] div_q;
   logic wr_en;

   // effective key count, clamped to 1..MaxKeys
   always_comb begin
      if (nkeys_ff == '0) nsat = IdxW'(1);
      else if (32'(nkeys_ff) > MaxKeys) nsat = IdxW'(MaxKeys);
      else nsat = IdxW'(nkeys_ff);
   end

   assign wr_en = req_valid && req_ready && (req_data.command == CmdWrite)
                  && (32'(req_data.key_slot) < MaxKeys);

   kcs_key_store #(.MaxKeys(MaxKeys), .AddrW(AddrW)) u_store (
      .clock(clock),
      .wr_en(wr_en),
      .wr_addr(AddrW'(req_data.key_slot)),
      .wr_time(req_data.key_time),
      .wr_val({req_data.key_w, req_data.key_z, req_data.key_y, req_data.key_x}),
      .rd_addr(rd_addr),
      .rd_time(rd_time),
      .rd_val(rd_val)
   );

   kcs_divider u_div (
      .clock(clock),
      .reset(reset),
      .start(div_start),
      .num(t_ff - t0_ff),
      .den(rd_time - t0_ff),
      .done(div_done),
      .quot(div_q)
   );

   function automatic logic signed [31:0] lerp_sum(logic signed [31:0] a,
                                                   logic signed [49:0] p);
      logic signed [34:0] s;
      begin
         s = 35'(a) + 35'(p >>> 16);
         if (s > 35'sd2147483647) lerp_sum = 32'sh7fffffff;
         else if (s < -35'sd2147483648) lerp_sum = 32'sh80000000;
         else lerp_sum = s[31:0];
      end
   endfunction

   always_comb begin
      state_in = state_ff;
      idx_in = idx_ff;
      t_in = t_ff;
      t0_in = t0_ff;
      va_in = va_ff;
      vb_in = vb_ff;
      f_in = f_ff;
      last_in = last_ff;
      held_in = held_ff;
      rspv_in = rspv_ff;
      div_start = 1'b0;
      rd_addr = idx_ff[AddrW-1:0];
      req_ready = 1'b0;
      for (int k = 0; k < 4; k++) prod_in[k] = prod_ff[k];
      if (rspv_ff && rsp_ready) rspv_in = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = !rspv_ff;
            rd_addr = '0;
            if (req_valid && req_ready && req_data.command == CmdSample) begin
               t_in = req_data.sample_time;
               idx_in = '0;
               state_in = ST_RD0;
            end
         end
         ST_RD0: begin
            state_in = ST_CHK0;
         end
         ST_CHK0: begin
            if (nsat == IdxW'(1) || t_ff <= rd_time) begin
               last_in = rd_val;
               held_in = 1'b0;
               state_in = ST_OUT;
            end else begin
               t0_in = rd_time;
               va_in = rd_val;
               idx_in = IdxW'(1);
               state_in = ST_SRCH;
            end
         end
         ST_SRCH: begin
            // memory read of key idx in flight
            state_in = ST_SCMP;
         end
         ST_SCMP: begin
            if (t0_ff <= t_ff && t_ff <= rd_time) begin
               vb_in = rd_val;
               if (rd_time == t0_ff) begin
                  f_in = '0;
                  state_in = ST_MUL;
               end else begin
                  div_start = 1'b1;
                  state_in = ST_DIV;
               end
            end else if (idx_ff + IdxW'(1) >= nsat) begin
               held_in = 1'b1;
               state_in = ST_OUT;
            end else begin
               t0_in = rd_time;
               va_in = rd_val;
               idx_in = idx_ff + IdxW'(1);
               state_in = ST_SRCH;
            end
         end
         ST_DIV: begin
            rd_addr = idx_ff[AddrW-1:0];
            if (div_done) begin
               f_in = div_q;
               state_in = ST_MUL;
            end
         end
         ST_RDB: state_in = ST_MUL;
         ST_MUL: begin
            for (int k = 0; k < 4; k++)
               prod_in[k] = (33'(signed'(vb_ff[32*k +: 32])) -
                             33'(signed'(va_ff[32*k +: 32]))) * $signed({1'b0, f_ff});
            state_in = ST_LERP;
         end
         ST_LERP: begin
            for (int k = 0; k < 4; k++)
               last_in[32*k +: 32] = lerp_sum(signed'(va_ff[32*k +: 32]), prod_ff[k]);
            held_in = 1'b0;
            state_in = ST_OUT;
         end
         ST_OUT: begin
            rspv_in = 1'b1;
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         nkeys_ff <= CountW'(1);
         last_ff <= '0;
         held_ff <= 1'b0;
         rspv_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_we) nkeys_ff <= csr_wdata;
         last_ff <= last_in;
         held_ff <= held_in;
         rspv_ff <= rspv_in;
      end
      idx_ff <= idx_in;
      t_ff <= t_in;
      t0_ff <= t0_in;
      va_ff <= va_in;
      vb_ff <= vb_in;
      f_ff <= f_in;
      for (int k = 0; k < 4; k++) prod_ff[k] <= prod_in[k];
   end

   assign rsp_valid = rspv_ff;
   assign rsp_data.value_x = last_ff[31:0];
   assign rsp_data.value_y = last_ff[63:32];
   assign rsp_data.value_z = last_ff[95:64];
   assign rsp_data.value_w = last_ff[127:96];
   assign rsp_data.held = held_ff;
endmodule

### rtl/kcs_checker.sv
module kcs_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input kcs_pkg::req_type req_data,
   input logic rsp_valid,
   input logic rsp_ready,
   input kcs_pkg::rsp_type rsp_data
);
   import kcs_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("rsp changed while stalled");

   a_no_req_with_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("req taken while rsp pending");

   a_write_no_rsp: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_data.command == CmdWrite |=> !rsp_valid)
      else $error("write produced rsp");

   a_reset_quiet: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("rsp after reset");
endmodule

bind keyframe_curve_sampler kcs_checker u_chk (
   .clock(clock), .reset(reset),
   .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
   .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
);

### tb/keyframe_curve_sampler_tb.sv
module keyframe_curve_sampler_tb;
   import kcs_pkg::*;

   localparam int  NumKeys    = 256;
   localparam int  ItemTarget = 1800;
   // A full 256-key scan is the slowest sample; gaps and stalls add to each
   // beat. Several times the slowest honest run.
   localparam longint CycleLimit = 8000000;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp_data;
   logic    csr_we;
   logic [CountW-1:0] csr_wdata;

   keyframe_curve_sampler i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   // ---------------------------------------------------------------
   // Curve mirror: key table, last sampled value and key count
   // ---------------------------------------------------------------
   logic [31:0]        key_tm [NumKeys];
   logic signed [31:0] key_val [NumKeys][4];
   logic signed [31:0] last_val [4];
   logic [CountW-1:0]  key_count;

   rsp_type sample_queue[$];   // samples awaiting their response beat

   int     errors = 0;
   int     beats_sent = 0;
   int     samples_seen = 0;
   bit     calm = 0;           // no idling in the closing stretch
   longint cycles = 0;

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   // Run watchdog
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CycleLimit) begin
         $display("%0t timeout: %0d samples still pending", $time, sample_queue.size());
         $display("Some tests failed");
         $finish;
      end
   end

   // Lerp one component: a + floor((b-a)*f/65536), clamped to 32 bits signed.
   function automatic logic signed [31:0] lerp_clamp(logic signed [31:0] a,
                                                     logic signed [31:0] b,
                                                     longint f);
      longint prod;
      longint sum;
      prod = (longint'(b) - longint'(a)) * f;
      sum  = longint'(a) + (prod >>> 16);   // arithmetic shift = floor
      if (sum > 64'sd2147483647)
         sum = 64'sd2147483647;
      if (sum < -64'sd2147483648)
         sum = -64'sd2147483648;
      return sum[31:0];
   endfunction

   // Apply one request beat to the mirror; returns 1 and the expected
   // response for a sample, 0 for a key write.
   function automatic bit curve_step(req_type rq, output rsp_type rs);
      int          n;
      bit          hit;
      logic [31:0] t;
      logic [31:0] t0;
      logic [31:0] t1;
      longint      f;
      if (rq.command == CmdWrite) begin
         key_tm[rq.key_slot]     = rq.key_time;
         key_val[rq.key_slot][0] = rq.key_x;
         key_val[rq.key_slot][1] = rq.key_y;
         key_val[rq.key_slot][2] = rq.key_z;
         key_val[rq.key_slot][3] = rq.key_w;
         return 0;
      end
      n = (key_count == 0) ? 1 : (key_count > NumKeys) ? NumKeys : key_count;
      t = rq.sample_time;
      hit = 0;
      if (n == 1 || t <= key_tm[0]) begin
         for (int c = 0; c < 4; c++)
            last_val[c] = key_val[0][c];
         hit = 1;
      end else begin
         for (int i = 0; i + 1 < n; i++) begin
            t0 = key_tm[i];
            t1 = key_tm[i + 1];
            if (!hit && t0 <= t && t <= t1) begin
               f = 0;   // zero-length segment keeps its start value
               if (t1 != t0)
                  f = ((longint'(t) - longint'(t0)) << 16) /
                      (longint'(t1) - longint'(t0));
               for (int c = 0; c < 4; c++)
                  last_val[c] = lerp_clamp(key_val[i][c], key_val[i + 1][c], f);
               hit = 1;
            end
         end
      end
      rs.value_x = last_val[0];
      rs.value_y = last_val[1];
      rs.value_z = last_val[2];
      rs.value_w = last_val[3];
      rs.held    = !hit;
      return 1;
   endfunction

   // ---------------------------------------------------------------
   // Response side: stall bursts plus one long hold-off
   // ---------------------------------------------------------------
   initial begin
      int  burst;
      bit  long_done;
      long_done = 0;
      rsp_ready = 0;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (!long_done && samples_seen >= 40) begin
            // long hold-off: the block fills and backs up the request side
            long_done = 1;
            rsp_ready <= 0;
            repeat (600) @(posedge clock);
         end
         if (!calm && $urandom_range(0, 9) == 0) begin
            burst = $urandom_range(1, 19);
            rsp_ready <= 0;
            repeat (burst) @(posedge clock);
         end
         rsp_ready <= 1;
         if (!calm && $urandom_range(0, 3) == 0)
            repeat ($urandom_range(5, 40)) @(posedge clock);
      end
   end

   // Response checker
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         samples_seen <= samples_seen + 1;
         if (sample_queue.size() == 0) begin
            $display("%0t unexpected response %h", $time, rsp_data);
            errors++;
         end else begin
            want = sample_queue.pop_front();
            if (rsp_data.value_x !== want.value_x) begin
               $display("%0t value_x exp %h got %h", $time, want.value_x, rsp_data.value_x);
               errors++;
            end
            if (rsp_data.value_y !== want.value_y) begin
               $display("%0t value_y exp %h got %h", $time, want.value_y, rsp_data.value_y);
               errors++;
            end
            if (rsp_data.value_z !== want.value_z) begin
               $display("%0t value_z exp %h got %h", $time, want.value_z, rsp_data.value_z);
               errors++;
            end
            if (rsp_data.value_w !== want.value_w) begin
               $display("%0t value_w exp %h got %h", $time, want.value_w, rsp_data.value_w);
               errors++;
            end
            if (rsp_data.held !== want.held) begin
               $display("%0t held exp %b got %b", $time, want.held, rsp_data.held);
               errors++;
            end
         end
      end
   end

   // ---------------------------------------------------------------
   // Request side
   // ---------------------------------------------------------------
   typedef struct {
      bit                is_cfg;
      logic [CountW-1:0] count;
      req_type           rq;
      bit                has_want;
      rsp_type           want;
   } step_row;

   step_row script[$];

   function automatic req_type key_beat(int slot, logic [31:0] t, logic [31:0] x,
                                        logic [31:0] y, logic [31:0] z, logic [31:0] w);
      req_type rq;
      rq = '0;
      rq.command = CmdWrite;
      rq.key_slot = 8'(slot);
      rq.key_time = t;
      rq.key_x = x;
      rq.key_y = y;
      rq.key_z = z;
      rq.key_w = w;
      rq.sample_time = $urandom;   // don't-care on a write
      return rq;
   endfunction

   function automatic req_type sample_beat(logic [31:0] t);
      req_type rq;
      rq = '0;
      rq.command = CmdSample;
      rq.sample_time = t;
      rq.key_slot = 8'($urandom);  // don't-care on a sample
      rq.key_time = $urandom;
      return rq;
   endfunction

   function automatic void add_row(req_type rq);
      step_row r;
      r = '{default: '0};
      r.rq = rq;
      script.push_back(r);
   endfunction

   function automatic void add_checked(req_type rq, rsp_type want);
      step_row r;
      r = '{default: '0};
      r.rq = rq;
      r.has_want = 1;
      r.want = want;
      script.push_back(r);
   endfunction

   function automatic void add_cfg(int n);
      step_row r;
      r = '{default: '0};
      r.is_cfg = 1;
      r.count = CountW'(n);
      script.push_back(r);
   endfunction

   function automatic logic [31:0] pick_value();
      case ($urandom_range(0, 9))
         0: return 32'h7fffffff;
         1: return 32'h80000000;
         2: return 32'h0;
         3: return 32'hffffffff;
         default: return $urandom;
      endcase
   endfunction

   // One beat; valid held until taken, gaps only between beats.
   task automatic send_beat(req_type rq, bit has_want, rsp_type want);
      rsp_type exp_rsp;
      if (!calm && $urandom_range(0, 7) == 0) begin
         req_valid <= 0;
         repeat ($urandom_range(1, 19)) @(posedge clock);
      end
      req_valid <= 1;
      req_data  <= rq;
      do @(posedge clock); while (!req_ready);
      beats_sent++;
      if (curve_step(rq, exp_rsp))
         sample_queue.push_back(has_want ? want : exp_rsp);
   endtask

   // Key count changes only with the block idle.
   task automatic set_key_count(int n);
      req_valid <= 0;
      while (sample_queue.size() != 0)
         @(posedge clock);
      repeat (8) @(posedge clock);   // let a trailing key write settle
      csr_we    <= 1;
      csr_wdata <= CountW'(n);
      @(posedge clock);
      csr_we    <= 0;
      key_count = CountW'(n);
   endtask

   // Load keys 0..n-1 in ascending time, some zero-length segments.
   task automatic load_curve(int n);
      longint t;
      rsp_type dummy;
      t = ($urandom_range(0, 1) != 0) ? $urandom_range(0, 32'h0010_0000) : $urandom;
      for (int i = 0; i < n; i++) begin
         if (t > 64'hffffffff)
            t = 64'hffffffff;
         send_beat(key_beat(i, t[31:0], pick_value(), pick_value(), pick_value(),
                            pick_value()), 0, dummy);
         case ($urandom_range(0, 9))
            0: t = t;
            1: t = t + 1;
            2: t = t + $urandom;
            default: t = t + $urandom_range(1, 32'h0004_0000);
         endcase
      end
   endtask

   task automatic random_traffic(int n, int beats);
      int          eff;
      int          i;
      logic [31:0] t;
      rsp_type     dummy;
      eff = (n == 0) ? 1 : (n > NumKeys) ? NumKeys : n;
      repeat (beats) begin
         if ($urandom_range(0, 9) < 2) begin
            // stray key write, may unsort the curve; slots past the curve may be unwritten
            i = $urandom_range(0, 4) == 0 ? $urandom_range(0, NumKeys - 1)
                                          : $urandom_range(0, eff - 1);
            t = ($urandom_range(0, 1) != 0 && i < eff) ? key_tm[i] + $urandom_range(0, 255)
                                                       : $urandom;
            send_beat(key_beat(i, t, pick_value(), pick_value(), pick_value(),
                               pick_value()), 0, dummy);
         end else begin
            i = $urandom_range(0, eff - 1);
            case ($urandom_range(0, 9))
               0: t = $urandom;
               1: t = 32'hffffffff;
               2: t = 0;
               3: t = key_tm[i];
               default: begin
                  if (i + 1 < eff && key_tm[i + 1] > key_tm[i])
                     t = key_tm[i] + $urandom_range(0, key_tm[i + 1] - key_tm[i]);
                  else
                     t = key_tm[i] + $urandom_range(0, 3);
               end
            endcase
            send_beat(sample_beat(t), 0, dummy);
         end
      end
   endtask

   initial begin
      step_row r;
      rsp_type k0;
      int      n;
      int      plan[$];
      int      phase;

      reset     = 1;
      req_valid = 0;
      req_data  = '0;
      csr_we    = 0;
      csr_wdata = '0;
      key_count = 1;
      for (int c = 0; c < 4; c++)
         last_val[c] = '0;
      repeat (5) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // Directed: key 0 alone, extremes, segment ends, past-the-end hold,
      // zero-length segment, key count zero.
      k0 = '{value_x: 32'h7fffffff, value_y: 32'h80000000,
             value_z: 32'h0, value_w: 32'hffffffff, held: 1'b0};
      add_row(key_beat(0, 32'h0001_0000, 32'h7fffffff, 32'h80000000, 32'h0, 32'hffffffff));
      add_checked(sample_beat(32'h0), k0);
      add_checked(sample_beat(32'hffffffff), k0);   // single key: always key 0
      add_cfg(4);
      add_row(key_beat(1, 32'h0002_0000, 32'h80000000, 32'h7fffffff, 32'h0001_0000, 32'h0));
      add_row(key_beat(2, 32'h0002_0000, 32'h0000_0005, 32'h0, 32'hffff_0000, 32'h1));
      add_row(key_beat(3, 32'h0003_0000, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                       32'h7fffffff));
      add_row(key_beat(255, 32'hffffffff, 32'h80000000, 32'h80000000, 32'h80000000,
                       32'h80000000));
      add_checked(sample_beat(32'h0001_0000), k0);  // exactly at key 0
      add_row(sample_beat(32'h0001_8000));          // full-swing midpoint
      add_row(sample_beat(32'h0001_0001));
      add_row(sample_beat(32'h0001_ffff));
      add_row(sample_beat(32'h0002_0000));          // segment end, f = 1.0
      add_row(sample_beat(32'h0002_8000));
      add_row(sample_beat(32'hffffffff));           // past the end: held
      add_row(sample_beat(32'h0003_0001));
      add_cfg(0);                                   // count zero acts as one
      add_checked(sample_beat(32'h0005_0000), k0);
      add_cfg(3);
      add_row(key_beat(1, 32'h0001_0000, 32'h1, 32'h2, 32'h3, 32'h4)); // zero-length
      add_row(sample_beat(32'h0001_8000));
      add_row(sample_beat(32'h0001_ffff));

      foreach (script[j]) begin
         r = script[j];
         if (r.is_cfg)
            set_key_count(r.count);
         else
            send_beat(r.rq, r.has_want, r.want);
      end

      // Random phases; big key counts get few samples since each scan is long.
      plan = '{2, 256, 3, 511, 5, 0, 8, 1, 16, 300, 40, 2};
      phase = 0;
      while (beats_sent < ItemTarget) begin
         if (phase < plan.size())
            n = plan[phase];
         else
            n = $urandom_range(2, 24);
         phase++;
         if (beats_sent > ItemTarget - 200)
            calm = 1;
         set_key_count(n);
         load_curve((n == 0) ? 1 : (n > NumKeys) ? NumKeys : n);
         random_traffic(n, (n > 64) ? 12 : $urandom_range(40, 120));
      end

      req_valid <= 0;
      while (sample_queue.size() != 0)
         @(posedge clock);
      repeat (100) @(posedge clock);

      if (errors == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule
